// File: rtl/core/kst_pkg.sv
// ============================================================================
// kst_pkg: shared types and constants for the keypad scan core
// Command and status groups, configuration view and the default key table.
// ============================================================================
package kst_pkg;

   localparam logic [1:0] ROW_LAST = 2'd3;
   localparam logic [3:0] COL_INV  = 4'h8;

   localparam logic [1:0] REG_TABLE_LENGTH  = 2'd0;
   localparam logic [1:0] REG_FIRST_DELAY   = 2'd1;
   localparam logic [1:0] REG_REPEAT_DELAY  = 2'd2;

   localparam logic [5:0] TABLE_LENGTH_RST = 6'd16;
   localparam logic [7:0] FIRST_DELAY_RST  = 8'd20;
   localparam logic [7:0] REPEAT_DELAY_RST = 8'd2;

   typedef struct packed {
      logic take;
      logic search;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic need_search;
      logic search_done;
   } status_type;

   typedef struct packed {
      logic [5:0] table_length;
      logic [7:0] first_delay;
      logic [7:0] repeat_delay;
   } cfg_type;

   function automatic logic [15:0] default_code(input logic [7:0] idx);
      logic [15:0] code;
      code = 16'd0;
      if (idx < 8'd16) begin
         code = 16'd1 << idx[3:0];
      end
      return code;
   endfunction

   function automatic logic [7:0] default_char(input logic [7:0] idx);
      logic [7:0] ch;
      unique case (idx)
         8'd0:    ch = 8'h64;
         8'd1:    ch = 8'h63;
         8'd2:    ch = 8'h61;
         8'd3:    ch = 8'h62;
         8'd4:    ch = 8'h0A;
         8'd5:    ch = 8'h39;
         8'd6:    ch = 8'h33;
         8'd7:    ch = 8'h36;
         8'd8:    ch = 8'h30;
         8'd9:    ch = 8'h38;
         8'd10:   ch = 8'h32;
         8'd11:   ch = 8'h35;
         8'd12:   ch = 8'h2A;
         8'd13:   ch = 8'h37;
         8'd14:   ch = 8'h31;
         8'd15:   ch = 8'h34;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: rtl/core/keypad_scan_translate_autorepeat_core.sv
// ============================================================================
// keypad_scan_translate_autorepeat_core: 4x4 keypad scanner with auto-repeat
// Scans one row per word, forms the key status after four rows and translates
// it through a writable scan-code table with first and repeat delays.
//
//   Channel   Direction   Handshake                Contents
//   req_      in          req_valid / req_stall    row sample or table write
//   rsp_      out         rsp_valid / rsp_stall    row drive, status, character
//   csr       in          psel / penable / pready  three configuration registers
//
// A row sample or table write moves from S_IDLE to S_OUT and is loaded into the
// output register once that register is free. A completed scan that emits a
// character adds a table search in S_SEARCH that reads one entry per cycle from
// the table RAM, over at most table_length entries, and stops at the first hit.
// The next word is accepted once the previous result sits in the output
// register, even while that result is stalled. Reset restores the default
// table at once through per-entry valid bits.
// ============================================================================
module keypad_scan_translate_autorepeat_core #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [3:0]  req_column_raw,
   input  logic [4:0]  req_entry_index,
   input  logic [15:0] req_entry_scan_code,
   input  logic [7:0]  req_entry_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_row_drive,
   output logic        rsp_scan_done,
   output logic [15:0] rsp_key_bitmap,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_key_char,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import kst_pkg::*;

   cmd_type    cmd;
   status_type status;
   cfg_type    cfg;

   kst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kst_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cfg                 (cfg),
      .req_func            (req_func),
      .req_column_raw      (req_column_raw),
      .req_entry_index     (req_entry_index),
      .req_entry_scan_code (req_entry_scan_code),
      .req_entry_char      (req_entry_char),
      .rsp_row_drive       (rsp_row_drive),
      .rsp_scan_done       (rsp_scan_done),
      .rsp_key_bitmap      (rsp_key_bitmap),
      .rsp_char_valid      (rsp_char_valid),
      .rsp_key_char        (rsp_key_char)
   );

   // A character is only emitted at the end of a scan with a key held.
   a_char_needs_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> rsp_scan_done && (rsp_key_bitmap != 16'd0))
      else $error("character emitted without a completed scan holding a key");

   a_code_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_key_char == 8'd0)
      else $error("character code set without a character");

   a_no_take_in_search: assert property (@(posedge clock) disable iff (reset)
      cmd.search |-> req_stall && !cmd.load)
      else $error("word accepted or loaded during the table search");

endmodule

// File: rtl/core/kst_ram.sv
// ============================================================================
// kst_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module kst_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/kst_csr.sv
// ============================================================================
// kst_csr: configuration registers
// APB-style register file for table length and the two repeat delays.
// ============================================================================
module kst_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output kst_pkg::cfg_type  cfg
);
   import kst_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_length <= TABLE_LENGTH_RST;
         cfg_ff.first_delay  <= FIRST_DELAY_RST;
         cfg_ff.repeat_delay <= REPEAT_DELAY_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_TABLE_LENGTH: cfg_ff.table_length <= pwdata[5:0];
            REG_FIRST_DELAY:  cfg_ff.first_delay  <= pwdata[7:0];
            REG_REPEAT_DELAY: cfg_ff.repeat_delay <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TABLE_LENGTH: prdata = {26'd0, cfg_ff.table_length};
         REG_FIRST_DELAY:  prdata = {24'd0, cfg_ff.first_delay};
         REG_REPEAT_DELAY: prdata = {24'd0, cfg_ff.repeat_delay};
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/kst_ctrl.sv
// ============================================================================
// kst_ctrl: sequencing controller
// Takes one word at a time, runs the table search and loads the output word.
// ============================================================================
module kst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  kst_pkg::status_type  status,
   output kst_pkg::cmd_type     cmd
);
   import kst_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.take   = (state_ff == S_IDLE) && req_valid;
      cmd.search = (state_ff == S_SEARCH);
      cmd.load   = (state_ff == S_OUT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= status.need_search ? S_SEARCH : S_OUT;
               end
            end
            S_SEARCH: begin
               if (status.search_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/kst_dp.sv
// ============================================================================
// kst_dp: scan and translation datapath
// Row accumulation, repeat countdown, key table with search and output word.
// ============================================================================
module kst_dp #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kst_pkg::cmd_type     cmd,
   output kst_pkg::status_type  status,
   input  kst_pkg::cfg_type     cfg,
   input  logic                 req_func,
   input  logic [3:0]           req_column_raw,
   input  logic [4:0]           req_entry_index,
   input  logic [15:0]          req_entry_scan_code,
   input  logic [7:0]           req_entry_char,
   output logic [3:0]           rsp_row_drive,
   output logic                 rsp_scan_done,
   output logic [15:0]          rsp_key_bitmap,
   output logic                 rsp_char_valid,
   output logic [7:0]           rsp_key_char
);
   import kst_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int LW = $clog2(TABLE_ENTRIES + 1);

   logic [1:0]  row_ff;
   logic [15:0] acc_ff;
   logic [15:0] cur_ff;
   logic [15:0] prev_ff;
   logic [7:0]  cnt_ff;

   logic        st_done_ff;
   logic        st_valid_ff;
   logic [7:0]  st_code_ff;

   logic [3:0]  out_row_ff;
   logic        out_done_ff;
   logic [15:0] out_status_ff;
   logic        out_valid_ff;
   logic [7:0]  out_code_ff;

   logic [LW-1:0]            ptr_ff;
   logic                     rd_pend_ff;
   logic                     rd_vld_ff;
   logic [15:0]              rd_dcode_ff;
   logic [7:0]               rd_dchar_ff;
   logic [TABLE_ENTRIES-1:0] vbits_ff;

   logic [3:0]    nib;
   logic [15:0]   acc_next;
   logic [15:0]   stat_new;
   logic          last_row;
   logic          emit_new;
   logic [LW-1:0] limit;
   logic [AW-1:0] ptr_idx;
   logic          issue;
   logic          wr_ok;
   logic [AW-1:0] waddr;
   logic          ram_we;
   logic [23:0]   ram_q;
   logic [15:0]   entry_code;
   logic [7:0]    entry_char;
   logic          match;

   assign nib      = req_column_raw ^ COL_INV;
   assign acc_next = {acc_ff[11:0], nib};
   assign stat_new = ~acc_next;
   assign last_row = (row_ff == ROW_LAST);
   assign emit_new = (stat_new != 16'd0) && ((stat_new != prev_ff) || (cnt_ff <= 8'd1));

   assign status.need_search = !req_func && last_row && emit_new;

   always_comb begin
      if (32'(cfg.table_length) > TABLE_ENTRIES) begin
         limit = LW'(TABLE_ENTRIES);
      end else begin
         limit = LW'(cfg.table_length);
      end
   end

   assign ptr_idx = ptr_ff[AW-1:0];
   assign issue   = cmd.search && (ptr_ff < limit);
   assign wr_ok   = 32'(req_entry_index) < TABLE_ENTRIES;
   assign waddr   = AW'(req_entry_index);
   assign ram_we  = cmd.take && req_func && wr_ok;

   kst_ram #(
      .WIDTH (24),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr),
      .wdata ({req_entry_scan_code, req_entry_char}),
      .re    (issue),
      .raddr (ptr_idx),
      .rdata (ram_q)
   );

   assign entry_code = rd_vld_ff ? ram_q[23:8] : rd_dcode_ff;
   assign entry_char = rd_vld_ff ? ram_q[7:0]  : rd_dchar_ff;
   assign match      = cmd.search && rd_pend_ff && (entry_code == cur_ff);

   assign status.search_done = match || (cmd.search && !rd_pend_ff && !issue);

   // Scan state, valid bits and the search pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= 2'd0;
         acc_ff     <= 16'd0;
         cur_ff     <= 16'd0;
         prev_ff    <= 16'd0;
         cnt_ff     <= 8'd0;
         vbits_ff   <= '0;
         ptr_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else if (cmd.take) begin
         ptr_ff     <= '0;
         rd_pend_ff <= 1'b0;
         if (req_func) begin
            if (wr_ok) begin
               vbits_ff[waddr] <= 1'b1;
            end
         end else begin
            row_ff <= row_ff + 2'd1;
            if (last_row) begin
               acc_ff  <= 16'd0;
               cur_ff  <= stat_new;
               prev_ff <= stat_new;
               if (stat_new != 16'd0) begin
                  if (stat_new != prev_ff) begin
                     cnt_ff <= cfg.first_delay;
                  end else if (cnt_ff <= 8'd1) begin
                     cnt_ff <= cfg.repeat_delay;
                  end else begin
                     cnt_ff <= cnt_ff - 8'd1;
                  end
               end
            end else begin
               acc_ff <= acc_next;
            end
         end
      end else if (cmd.search) begin
         rd_pend_ff <= issue;
         if (issue) begin
            ptr_ff <= ptr_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         st_done_ff  <= !req_func && last_row;
         st_valid_ff <= status.need_search;
         st_code_ff  <= 8'd0;
      end else if (match) begin
         st_code_ff <= entry_char;
      end
      if (issue) begin
         rd_vld_ff   <= vbits_ff[ptr_idx];
         rd_dcode_ff <= default_code(8'(ptr_idx));
         rd_dchar_ff <= default_char(8'(ptr_idx));
      end
      if (cmd.load) begin
         out_row_ff    <= 4'(~(4'd1 << row_ff));
         out_done_ff   <= st_done_ff;
         out_status_ff <= cur_ff;
         out_valid_ff  <= st_valid_ff;
         out_code_ff   <= st_code_ff;
      end
   end

   assign rsp_row_drive  = out_row_ff;
   assign rsp_scan_done  = out_done_ff;
   assign rsp_key_bitmap = out_status_ff;
   assign rsp_char_valid = out_valid_ff;
   assign rsp_key_char   = out_code_ff;

endmodule

// File: verif/tb_keypad_scan_translate_autorepeat_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_keypad_scan_translate_autorepeat_core: self-checking keypad scanner bench
// Drives row samples and table writes through the request channel. Every
// accepted word is predicted in step with the core: row drive, scan
// completion, key status, and the character from the table search with its
// first and repeat delays. Each result word is checked against the oldest
// prediction. A directed table comes first. It is followed by random phases
// that hold keys over many scans under several register settings, with
// random gaps on the request channel and stalls on the response channel.
// ============================================================================
module tb_keypad_scan_translate_autorepeat_core;
   import kst_pkg::*;

   typedef enum logic {FN_SAMPLE = 1'b0, FN_WRITE = 1'b1} func_type;

   typedef struct packed {
      func_type    func;
      logic [3:0]  col;
      logic [4:0]  idx;
      logic [15:0] code;
      logic [7:0]  ch;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  row_drive;
      logic        scan_done;
      logic [15:0] key_bitmap;
      logic        char_valid;
      logic [7:0]  key_char;
   } rsp_word_type;

   typedef struct packed {
      req_word_type w;
      logic         typed;
      rsp_word_type r;
   } dir_row_type;

   typedef struct packed {
      logic [5:0] len;
      logic [7:0] first;
      logic [7:0] rep;
      logic       quiet;
   } phase_type;

   localparam int N_ENTRIES = 32;
   localparam int N_DIR     = 27;
   localparam int N_PHASES  = 7;
   localparam int PHASE_LEN = 175;

   localparam logic [7:0] DEFAULT_CHAR [16] = '{
      8'h64, 8'h63, 8'h61, 8'h62, 8'h0A, 8'h39, 8'h33, 8'h36,
      8'h30, 8'h38, 8'h32, 8'h35, 8'h2A, 8'h37, 8'h31, 8'h34
   };

   localparam dir_row_type DIR_TAB [N_DIR] = '{
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hD, 1'b0, 16'h0000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hB, 1'b0, 16'h0000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'h7, 1'b0, 16'h0000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hE, 1'b1, 16'h0000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'hF, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hD, 1'b0, 16'h0000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hB, 1'b0, 16'h0000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'h7, 1'b0, 16'h0000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hE, 1'b1, 16'h8000, 1'b1, 8'h34}},
      '{'{FN_WRITE,  4'h0, 5'd31, 16'hFFFF, 8'hFF}, 1'b1, '{4'hE, 1'b0, 16'h8000, 1'b0, 8'h00}},
      '{'{FN_WRITE,  4'hF, 5'd16, 16'h0000, 8'h00}, 1'b1, '{4'hE, 1'b0, 16'h8000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h8, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hD, 1'b0, 16'h8000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h8, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hB, 1'b0, 16'h8000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h8, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'h7, 1'b0, 16'h8000, 1'b0, 8'h00}},
      '{'{FN_SAMPLE, 4'h8, 5'd0,  16'h0000, 8'h00}, 1'b1, '{4'hE, 1'b1, 16'hFFFF, 1'b1, 8'h00}},
      '{'{FN_SAMPLE, 4'h8, 5'd31, 16'hFFFF, 8'hFF}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h8, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h8, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h8, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_WRITE,  4'h7, 5'd17, 16'h0001, 8'h55}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h7, 5'd0,  16'h0000, 8'h00}, 1'b0, '0},
      '{'{FN_SAMPLE, 4'h6, 5'd0,  16'h0000, 8'h00}, 1'b0, '0}
   };

   localparam phase_type PHASES [N_PHASES] = '{
      '{6'd32, 8'd1,   8'd1,   1'b0},
      '{6'd0,  8'd2,   8'd3,   1'b0},
      '{6'd63, 8'd0,   8'd0,   1'b1},
      '{6'd32, 8'd255, 8'd255, 1'b0},
      '{6'd20, 8'd3,   8'd1,   1'b0},
      '{6'd1,  8'd4,   8'd2,   1'b0},
      '{6'd32, 8'd2,   8'd0,   1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [3:0]  req_column_raw = 4'h0;
   logic [4:0]  req_entry_index = 5'd0;
   logic [15:0] req_entry_scan_code = 16'h0000;
   logic [7:0]  req_entry_char = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_row_drive;
   logic        rsp_scan_done;
   logic [15:0] rsp_key_bitmap;
   logic        rsp_char_valid;
   logic [7:0]  rsp_key_char;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'h0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   keypad_scan_translate_autorepeat_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_column_raw      (req_column_raw),
      .req_entry_index     (req_entry_index),
      .req_entry_scan_code (req_entry_scan_code),
      .req_entry_char      (req_entry_char),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_row_drive       (rsp_row_drive),
      .rsp_scan_done       (rsp_scan_done),
      .rsp_key_bitmap      (rsp_key_bitmap),
      .rsp_char_valid      (rsp_char_valid),
      .rsp_key_char        (rsp_key_char),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow of the core's scan state, configuration and key table.
   cfg_type     cfg;
   logic [1:0]  row_pos;
   logic [15:0] scan_acc;
   logic [15:0] cur_status;
   logic [15:0] prev_status;
   logic [7:0]  countdown;
   logic [15:0] tab_code [N_ENTRIES];
   logic [7:0]  tab_char [N_ENTRIES];

   rsp_word_type pending_rsp [$];
   int           n_fail = 0;
   logic         quiet = 1'b0;
   int           stall_left = 0;

   function automatic rsp_word_type scan_and_translate(input req_word_type w);
      rsp_word_type r;
      int           n;
      logic         hit;
      r = '0;
      if (w.func == FN_WRITE) begin
         tab_code[w.idx] = w.code;
         tab_char[w.idx] = w.ch;
      end else begin
         scan_acc = {scan_acc[11:0], w.col ^ COL_INV};
         if (row_pos == ROW_LAST) begin
            cur_status  = ~scan_acc;
            scan_acc    = 16'h0000;
            r.scan_done = 1'b1;
            if (cur_status != 16'h0000) begin
               if (cur_status != prev_status) begin
                  countdown    = cfg.first_delay;
                  r.char_valid = 1'b1;
               end else if (countdown <= 8'd1) begin
                  countdown    = cfg.repeat_delay;
                  r.char_valid = 1'b1;
               end else begin
                  countdown = countdown - 8'd1;
               end
               if (r.char_valid) begin
                  n   = (cfg.table_length > N_ENTRIES) ? N_ENTRIES : int'(cfg.table_length);
                  hit = 1'b0;
                  for (int i = 0; i < n; i++) begin
                     if (!hit && tab_code[i] == cur_status) begin
                        r.key_char = tab_char[i];
                        hit        = 1'b1;
                     end
                  end
               end
            end
            prev_status = cur_status;
         end
         row_pos = row_pos + 2'd1;
      end
      r.row_drive  = ~(4'b0001 << row_pos);
      r.key_bitmap = cur_status;
      return r;
   endfunction

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type typed_rsp);
      int           gap;
      rsp_word_type pred;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= w.func;
      req_column_raw      <= w.col;
      req_entry_index     <= w.idx;
      req_entry_scan_code <= w.code;
      req_entry_char      <= w.ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = scan_and_translate(w);
      pending_rsp.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic drain();
      if (pending_rsp.size() != 0) begin
         req_valid <= 1'b0;
         while (pending_rsp.size() != 0) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_TABLE_LENGTH: cfg.table_length = val[5:0];
         REG_FIRST_DELAY:  cfg.first_delay  = val[7:0];
         REG_REPEAT_DELAY: cfg.repeat_delay = val[7:0];
         default: ;
      endcase
   endtask

   // Random scans: keys are mostly held for several scans so that the delays
   // run out, with releases, chords, noisy rows and table writes mixed in.
   task automatic run_random(input int n_items);
      int           sent;
      int           pick;
      int           hold;
      logic [15:0]  held;
      logic [3:0]   nib;
      req_word_type w;
      sent = 0;
      held = 16'h0000;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 && held != 16'h0000) begin
            held = held;
         end else if (pick < 65) begin
            held = 16'h0001 << $urandom_range(0, 15);
         end else if (pick < 75) begin
            held = 16'h0000;
         end else if (pick < 85) begin
            held = 16'($urandom);
         end else begin
            held = (16'h0001 << $urandom_range(0, 15)) | (16'h0001 << $urandom_range(0, 15));
         end
         if ($urandom_range(0, 99) == 0) begin
            drain();
         end
         hold = $urandom_range(1, 6);
         for (int s = 0; s < hold; s++) begin
            for (int r = 0; r < 4; r++) begin
               if ($urandom_range(0, 99) < 6) begin
                  w.func = FN_WRITE;
                  w.col  = 4'($urandom);
                  w.idx  = 5'($urandom);
                  w.code = $urandom_range(0, 1) ? 16'h0001 << $urandom_range(0, 15)
                                                : 16'($urandom);
                  w.ch   = 8'($urandom);
                  send_word(w, 1'b0, '0);
                  sent++;
               end
               nib = ~held[15 - 4 * r -: 4];
               if ($urandom_range(0, 99) < 5) begin
                  nib = 4'($urandom);
               end
               w.func = FN_SAMPLE;
               w.col  = nib ^ COL_INV;
               w.idx  = 5'($urandom);
               w.code = 16'($urandom);
               w.ch   = 8'($urandom);
               send_word(w, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result word with no prediction waiting");
            n_fail++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_row_drive !== want.row_drive) begin
               $error("row_drive: expected %h, actual %h", want.row_drive, rsp_row_drive);
               n_fail++;
            end
            if (rsp_scan_done !== want.scan_done) begin
               $error("scan_done: expected %h, actual %h", want.scan_done, rsp_scan_done);
               n_fail++;
            end
            if (rsp_key_bitmap !== want.key_bitmap) begin
               $error("key_bitmap: expected %h, actual %h", want.key_bitmap, rsp_key_bitmap);
               n_fail++;
            end
            if (rsp_char_valid !== want.char_valid) begin
               $error("char_valid: expected %h, actual %h", want.char_valid, rsp_char_valid);
               n_fail++;
            end
            if (rsp_key_char !== want.key_char) begin
               $error("key_char: expected %h, actual %h", want.key_char, rsp_key_char);
               n_fail++;
            end
         end
      end
   end

   initial begin
      cfg.table_length = TABLE_LENGTH_RST;
      cfg.first_delay  = FIRST_DELAY_RST;
      cfg.repeat_delay = REPEAT_DELAY_RST;
      row_pos     = 2'd0;
      scan_acc    = 16'h0000;
      cur_status  = 16'h0000;
      prev_status = 16'h0000;
      countdown   = 8'd0;
      for (int i = 0; i < N_ENTRIES; i++) begin
         tab_code[i] = (i < 16) ? 16'h0001 << i : 16'h0000;
         tab_char[i] = (i < 16) ? DEFAULT_CHAR[i] : 8'h00;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIR_TAB[k]) begin
         send_word(DIR_TAB[k].w, DIR_TAB[k].typed, DIR_TAB[k].r);
      end
      foreach (PHASES[p]) begin
         drain();
         quiet = PHASES[p].quiet;
         write_reg(REG_TABLE_LENGTH, 32'(PHASES[p].len));
         write_reg(REG_FIRST_DELAY, 32'(PHASES[p].first));
         write_reg(REG_REPEAT_DELAY, 32'(PHASES[p].rep));
         run_random(PHASE_LEN);
      end
      drain();
      repeat (80) @(posedge clock);
      if (n_fail == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
